>>> rtl/core/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

  // sync word
  localparam logic [7:0] SYNC_FIRST  = 8'h7B;
  localparam logic [7:0] SYNC_SECOND = 8'hEA;

  // payload store per frame
  localparam int PAYLOAD_DEPTH = 32;
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
  localparam int IDX_W         = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  // two banks so a frame can be collected while the previous one drains
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  // length register
  localparam int             LEN_W     = 6;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_SYNC1 = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } back_state_e;

  typedef struct packed {
    logic             good;
    logic             bank;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

  // zero acts as one, anything above the store depth saturates
  function automatic logic [CNT_W-1:0] eff_len(logic [LEN_W-1:0] len);
    localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    logic [CMP_W-1:0] n;
    n = CMP_W'(len);
    if (n == CMP_W'(0)) n = CMP_W'(1);
    if (n > CMP_W'(PAYLOAD_DEPTH)) n = CMP_W'(PAYLOAD_DEPTH);
    return CNT_W'(n);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dfr_if.sv
`default_nettype none

interface dfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

interface dfr_cfg_if;
  import dfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] payload_length;
  modport source (output valid, output payload_length, input ready);
  modport sink   (input valid, input payload_length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dfr_ram.sv
`default_nettype none

module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/dfr_front.sv
`default_nettype none

module dfr_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  dfr_byte_if.sink                     in_i,
  input  wire logic [dfr_pkg::LEN_W-1:0] len_i,
  input  wire logic                    q_full_i,
  input  wire logic                    frame_done_i,
  output dfr_pkg::q_push_t             push_o,
  output dfr_pkg::ram_wr_t             wr_o
);
  import dfr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d, count_next;
  logic [7:0]       sum_q, sum_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;
  logic             beat;
  logic             good_push;

  always_comb begin
    case (phase_q)
      PH_DATA:  in_i.ready = (busy_q != 2'd2);
      PH_CHECK: in_i.ready = !q_full_i;
      default:  in_i.ready = 1'b1;
    endcase
  end

  assign beat = in_i.valid && in_i.ready;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    sum_d      = sum_q;
    bank_d     = bank_q;
    count_next = count_q;
    good_push  = 1'b0;
    wr_o.we    = 1'b0;
    wr_o.addr  = {bank_q, count_q[IDX_W-1:0]};
    wr_o.data  = in_i.rx_byte;
    push_o.valid      = 1'b0;
    push_o.cmd.good   = (in_i.rx_byte == sum_q);
    push_o.cmd.bank   = bank_q;
    push_o.cmd.count  = count_q;
    if (beat) begin
      case (phase_q)
        PH_HUNT: begin
          if (in_i.rx_byte == SYNC_FIRST) phase_d = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (in_i.rx_byte == SYNC_SECOND) begin
            phase_d = PH_DATA;
            count_d = '0;
            sum_d   = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (count_q < CNT_W'(PAYLOAD_DEPTH)) begin
            wr_o.we    = 1'b1;
            count_next = count_q + CNT_W'(1);
          end
          count_d = count_next;
          sum_d   = sum_q + in_i.rx_byte;
          if (count_next >= eff_len(len_i)) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          push_o.valid = 1'b1;
          good_push    = push_o.cmd.good;
          if (good_push) bank_d = !bank_q;
          phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // banks holding a good frame not yet drained
  always_comb begin
    busy_d = busy_q;
    if (good_push && !frame_done_i) busy_d = busy_q + 2'd1;
    else if (!good_push && frame_done_i) busy_d = busy_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      sum_q   <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dfr_queue.sv
`default_nettype none

module dfr_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dfr_pkg::q_push_t push_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output dfr_pkg::cmd_t         head_o
);
  import dfr_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_i.cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dfr_back.sv
`default_nettype none

module dfr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dfr_pkg::cmd_t head_i,
  input  wire logic          head_valid_i,
  output logic               pop_o,
  output dfr_pkg::ram_rd_t   rd_o,
  input  wire logic [7:0]    rdata_i,
  dfr_res_if.source          out_o,
  output logic               frame_done_o
);
  import dfr_pkg::*;

  back_state_e      state_q, state_d;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d;
  logic             rd_pend_q, rd_pend_d, rd_last_q, rd_last_d;
  logic             out_valid_q, out_valid_d;
  logic             out_kind_q, out_kind_d, out_last_q, out_last_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_free;

  assign out_free       = !out_valid_q || out_o.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.out_kind = out_kind_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

  always_comb begin
    state_d      = state_q;
    bank_d       = bank_q;
    count_d      = count_q;
    idx_d        = idx_q;
    rd_pend_d    = rd_pend_q;
    rd_last_d    = rd_last_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    frame_done_o = 1'b0;
    rd_o.re      = 1'b0;
    rd_o.addr    = {bank_q, idx_q[IDX_W-1:0]};
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          if (head_i.good) begin
            pop_o   = 1'b1;
            bank_d  = head_i.bank;
            count_d = head_i.count;
            idx_d   = '0;
            state_d = BK_RUN;
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            out_kind_d  = KIND_ERROR;
            out_byte_d  = '0;
            out_last_d  = 1'b1;
          end
        end
      end
      BK_RUN: begin
        if (rd_pend_q) begin
          // output register was freed when this read was issued
          rd_pend_d   = 1'b0;
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DATA;
          out_byte_d  = rdata_i;
          out_last_d  = rd_last_q;
          if (rd_last_q) begin
            state_d      = BK_IDLE;
            frame_done_o = 1'b1;
          end
        end else if (out_free) begin
          rd_o.re   = 1'b1;
          rd_pend_d = 1'b1;
          rd_last_d = (idx_q + CNT_W'(1) == count_q);
          idx_d     = idx_q + CNT_W'(1);
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    bank_q     <= bank_d;
    count_q    <= count_d;
    idx_q      <= idx_d;
    rd_last_q  <= rd_last_d;
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sync_framed_packet_deframer.sv
// input: one byte accepted per cycle; payload bytes stall only while both banks hold
//   undrained good frames, the checksum byte only while the command queue is full
// output: an error command goes from the queue straight into the output register, a good one
//   through ram reads into it, one result per ram read (one ram read in flight at a time)
// reset: rst_ni asynchronous active low; hunts for sync, length register reads 8,
//   queue and output empty; the payload ram is not cleared
`default_nettype none

module sync_framed_packet_deframer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dfr_byte_if.sink  in_i,
  dfr_res_if.source out_o,
  dfr_cfg_if.sink   cfg_i
);
  import dfr_pkg::*;

  // length register, always writable
  logic [LEN_W-1:0] len_q;

  // front to queue, queue to back
  q_push_t push;
  cmd_t    head;
  logic    q_full, q_valid, q_pop;

  // ram ports and bank release
  ram_wr_t ram_wr;
  ram_rd_t ram_rd;
  logic [7:0] ram_rdata;
  logic       frame_done;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_i.valid) begin
      len_q <= cfg_i.payload_length;
    end
  end

  // sync hunt, payload capture into the current bank, checksum compare
  dfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .len_i        (len_q),
    .q_full_i     (q_full),
    .frame_done_i (frame_done),
    .push_o       (push),
    .wr_o         (ram_wr)
  );

  // per-frame commands: good frame with bank and count, or checksum error
  dfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // two banks of payload, written by the front, read by the back
  dfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.re),
    .raddr_i (ram_rd.addr),
    .rdata_o (ram_rdata)
  );

  // drains a good frame beat by beat or emits the error beat
  dfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .rd_o         (ram_rd),
    .rdata_i      (ram_rdata),
    .out_o        (out_o),
    .frame_done_o (frame_done)
  );

endmodule

`default_nettype wire

>>> rtl/core/dfr_checker.sv
`default_nettype none

module dfr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_kind_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);
  import dfr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_kind_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // error result is a single beat with zero data
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_ERROR) |-> out_last_i && (out_byte_i == 8'h00))
    else $error("malformed error result");

  // valid drops only after a taken beat
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result withdrawn");

  // no result while held in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result during reset");

endmodule

bind sync_framed_packet_deframer dfr_checker u_dfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.out_kind),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);

`default_nettype wire

>>> sim/sync_framed_packet_deframer_tb.sv
`timescale 1ns / 100ps

import dfr_pkg::*;

// one result beat as it leaves the block
typedef struct packed {
  logic       kind;
  logic [7:0] data;
  logic       last;
} res_beat_t;

// mirrors the deframer and holds the result beats still owed by the block
class frame_scoreboard;
  phase_e           phase;
  int unsigned      stored;
  logic [7:0]       sum;
  logic [7:0]       payload [PAYLOAD_DEPTH];
  logic [LEN_W-1:0] length_reg;
  res_beat_t        owed_beats [$];
  int unsigned      errors;
  int unsigned      reported;
  int unsigned      beats_seen;

  function new();
    phase      = PH_HUNT;
    stored     = 0;
    sum        = 8'h00;
    length_reg = LEN_RESET;
    errors     = 0;
    reported   = 0;
    beats_seen = 0;
  endfunction

  function void set_length(logic [LEN_W-1:0] v);
    length_reg = v;
  endfunction

  // zero acts as one, above the store depth saturates
  function int unsigned frame_len();
    int unsigned n;
    n = length_reg;
    if (n == 0) n = 1;
    if (n > PAYLOAD_DEPTH) n = PAYLOAD_DEPTH;
    return n;
  endfunction

  function int unsigned pending();
    return owed_beats.size();
  endfunction

  // returns 0 only for a byte that hunting skips over
  function bit note_byte(logic [7:0] b);
    res_beat_t beat;
    bit        used;
    used = 1'b1;
    case (phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) phase = PH_SYNC1;
        else used = 1'b0;
      end
      PH_SYNC1: begin
        if (b == SYNC_SECOND) begin
          sum    = 8'h00;
          stored = 0;
          phase  = PH_DATA;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (stored < PAYLOAD_DEPTH) begin
          payload[stored] = b;
          stored++;
        end
        sum = sum + b;
        if (stored >= frame_len()) phase = PH_CHECK;
      end
      default: begin
        if (b == sum) begin
          for (int unsigned i = 0; i < stored; i++) begin
            beat.kind = KIND_DATA;
            beat.data = payload[i];
            beat.last = (i + 1 == stored);
            owed_beats.push_back(beat);
          end
        end else begin
          beat.kind = KIND_ERROR;
          beat.data = 8'h00;
          beat.last = 1'b1;
          owed_beats.push_back(beat);
        end
        phase = PH_HUNT;
      end
    endcase
    return used;
  endfunction

  function void check_beat(logic kind, logic [7:0] data, logic last);
    res_beat_t want;
    beats_seen++;
    if (owed_beats.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result beat: kind %b byte %h last %b", kind, data, last);
      end
      return;
    end
    want = owed_beats.pop_front();
    if (kind !== want.kind || data !== want.data || last !== want.last) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("beat mismatch: expected kind %b byte %h last %b, got kind %b byte %h last %b",
                 want.kind, want.data, want.last, kind, data, last);
      end
    end
  endfunction

  function void flush_owed();
    if (owed_beats.size() != 0) begin
      errors += owed_beats.size();
      $display("%0d result beats never arrived", owed_beats.size());
      owed_beats.delete();
    end
  endfunction
endclass

module sync_framed_packet_deframer_tb;

  // cycles to let the block settle once nothing is owed
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned LIMIT_CYCLES  = 800000;
  localparam int unsigned SEGMENT_BYTES = 30;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic clk_i;
  logic rst_ni;

  dfr_byte_if byte_if ();
  dfr_res_if  res_if ();
  dfr_cfg_if  cfg_if ();

  sync_framed_packet_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  frame_scoreboard board;

  // idle percentages per side, changed between phases of the run
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // long receiver hold-off, picked up and counted down by the result sink
  int unsigned hold_request;
  int unsigned consumed_bytes;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sink: checks every accepted beat, idles at random or holds off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        board.check_beat(res_if.out_kind, res_if.out_byte, res_if.out_last);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // one byte beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    if (board.note_byte(b)) consumed_bytes++;
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // sync word, payload at the current length, then a right or wrong checksum
  task automatic send_frame(input bit good);
    logic [7:0]  seq [$];
    logic [7:0]  b;
    logic [7:0]  total;
    int unsigned n;
    n     = board.frame_len();
    total = 8'h00;
    seq.push_back(SYNC_FIRST);
    seq.push_back(SYNC_SECOND);
    repeat (n) begin
      b     = 8'($urandom_range(0, 255));
      total = total + b;
      seq.push_back(b);
    end
    seq.push_back(good ? total : total + 8'($urandom_range(1, 255)));
    send_seq(seq);
  endtask

  // mostly whole frames, some broken sync words and some line noise
  task automatic send_random_chunk();
    logic [7:0]  seq [$];
    logic [7:0]  b;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      send_frame($urandom_range(0, 99) < 80);
    end else if (r < 84) begin
      seq.push_back(SYNC_FIRST);
      if ($urandom_range(0, 1) == 1) begin
        seq.push_back(SYNC_FIRST);
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == SYNC_SECOND);
        seq.push_back(b);
      end
      send_seq(seq);
    end else begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
      send_seq(seq);
    end
  endtask

  // stop offering and wait until the block owes nothing
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block drained and the byte channel idle
  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_if.valid          <= 1'b1;
    cfg_if.payload_length <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.set_length(v);
  endtask

  initial begin : stimulus
    logic [7:0]       seq [$];
    logic [LEN_W-1:0] seg_len [10];
    int unsigned      target;
    int unsigned      quiet;
    int unsigned      last_seen;

    seg_len = '{6'd3, 6'd32, 6'd1, 6'd8, 6'd63, 6'd2, 6'd0, 6'd12, 6'd5, 6'd4};

    board          = new();
    send_idle_pct  = 30;
    recv_idle_pct  = 85;
    hold_request   = 0;
    consumed_bytes = 0;
    cycle_count    = 0;

    rst_ni                <= 1'b0;
    byte_if.valid         <= 1'b0;
    byte_if.rx_byte       <= 8'h00;
    res_if.ready          <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.payload_length <= '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // length changed mid-frame: three bytes in at the reset length, then length 1,
    // so the next byte ends collection and all four come back
    seq = '{SYNC_FIRST, SYNC_SECOND, 8'h00, 8'hFF, 8'h80};
    send_seq(seq);
    wait_drained();
    write_length(6'd1);
    seq = '{8'h7F, 8'hFE};
    send_seq(seq);

    // second sync byte equal to the first sends it back to hunting, the EA after it
    // is skipped, then a frame with a wrong checksum
    seq = '{SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'h00};
    send_seq(seq);

    // checksum byte equal to the first sync byte; the EA after it must not sync
    seq = '{SYNC_FIRST, SYNC_SECOND, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND};
    send_seq(seq);

    // zero length takes one payload byte
    wait_drained();
    write_length(6'd0);
    seq = '{SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h01};
    send_seq(seq);

    // random part: each segment starts drained with a new length
    for (int seg = 0; seg < 10; seg++) begin
      if (seg < 4) begin
        send_idle_pct = 30;
        recv_idle_pct = 85;
      end else if (seg < 7) begin
        send_idle_pct = 85;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      write_length(seg_len[seg]);
      // last segment: receiver blocks while good short frames keep coming, both banks
      // fill and the byte input stalls
      if (seg == 9) hold_request = HOLD_CYCLES;
      target = consumed_bytes + SEGMENT_BYTES;
      while (consumed_bytes < target) begin
        if (seg == 9) send_frame(1'b1);
        else send_random_chunk();
      end
    end

    // drain, bounded by a stretch without any result beat
    byte_if.valid <= 1'b0;
    quiet     = 0;
    last_seen = board.beats_seen;
    while (board.pending() != 0 && quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (board.beats_seen != last_seen) begin
        last_seen = board.beats_seen;
        quiet     = 0;
      end else begin
        quiet++;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.flush_owed();

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
